@@ hdl/go_to_goal_velocity_law_top_defines.svh @@
// Assertion helpers shared by the RTL.
`ifndef GO_TO_GOAL_VELOCITY_LAW_TOP_DEFINES_SVH
`define GO_TO_GOAL_VELOCITY_LAW_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define GGV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define GGV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ggv_pkg.sv @@
`timescale 1ns / 1ps
package ggv_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 16;
    localparam int ITER_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int XW           = 34;   // CORDIC x/y
    localparam int ZW           = 35;   // angle, 2^-30 rad units
    localparam int EW           = 36;   // heading before wrap
    localparam int RND_SHIFT    = 30 - FRAC_BITS;

    localparam logic signed [ZW-1:0] HALF_PI_U30 = 35'sd1686629713;
    localparam logic signed [EW-1:0] PI_U30      = 36'sd3373259426;
    localparam logic signed [EW-1:0] TWO_PI_U30  = 36'sd6746518852;

    typedef enum logic [1:0] {
        ST_DRIVE   = 2'd0,
        ST_ALIGN   = 2'd1,
        ST_REACHED = 2'd2,
        ST_CANCEL  = 2'd3
    } ggv_status_t;

    typedef enum logic [2:0] {
        REG_DIST_TOL  = 3'd0,
        REG_LIN_GAIN  = 3'd1,
        REG_LIN_MAX   = 3'd2,
        REG_STEER_GN  = 3'd3,
        REG_ANGLE_TOL = 3'd4,
        REG_TURN_GAIN = 3'd5,
        REG_ANG_MAX   = 3'd6
    } ggv_reg_t;

    typedef struct packed {
        logic [14:0] dist_tolerance;
        logic [14:0] linear_gain;
        logic [14:0] linear_max;
        logic [14:0] steer_gain;
        logic [14:0] angle_tolerance;
        logic [14:0] turn_gain;
        logic [14:0] angular_max;
    } ggv_cfg_t;

    typedef struct packed {
        logic                  vld;
        logic                  cancel;
        logic                  drive;
        logic signed [15:0]    err_q;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
        logic [31:0]           rem;
        logic [31:0]           root;
    } ggv_iter_t;

    // atan(2^-i), truncated, 2^-30 rad
    function automatic logic signed [ZW-1:0] atan_u30(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 35'sd843314856;
            5'd1:  v = 35'sd497837829;
            5'd2:  v = 35'sd263043836;
            5'd3:  v = 35'sd133525158;
            5'd4:  v = 35'sd67021686;
            5'd5:  v = 35'sd33543515;
            5'd6:  v = 35'sd16775850;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194282;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048575;
            5'd11: v = 35'sd524287;
            5'd12: v = 35'sd262143;
            5'd13: v = 35'sd131071;
            5'd14: v = 35'sd65535;
            5'd15: v = 35'sd32767;
            5'd16: v = 35'sd16383;
            5'd17: v = 35'sd8191;
            5'd18: v = 35'sd4095;
            5'd19: v = 35'sd2047;
            5'd20: v = 35'sd1023;
            5'd21: v = 35'sd511;
            5'd22: v = 35'sd255;
            5'd23: v = 35'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/go_to_goal_velocity_law_top.sv @@
`timescale 1ns / 1ps
// Go-to-goal velocity law, Q4.12 fixed point, one control tick per transaction.
// Slave stream carries the goal offset and heading error in s_tdata and the
// cancel flag in s_tuser; the master stream returns linear and angular speed
// commands plus a status code (drive, align, reached, canceled).
// Gains and tolerances sit in seven 15-bit registers written through cfg_*;
// write them only while no transaction is in flight.
// Path from slave transaction to m_tvalid: two front stages, 16 CORDIC/
// square-root stages, one multiply stage, output register.
// Throughput: one transaction per cycle unless a result is held in the
// output register by m_tready low; there is no feedback between ticks.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults. When the receiver stalls, the whole pipeline freezes
// with it: s_tready drops only while a result waits in the output register
// and m_tready is low, so nothing is dropped or repeated.
`include "go_to_goal_velocity_law_top_defines.svh"
module go_to_goal_velocity_law_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // offset_x[15:0], offset_y[31:16], heading_error[47:32]
    input  logic        s_tuser,   // cancel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // linear_cmd[15:0], angular_cmd[31:16], status[33:32], 0
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [14:0] cfg_wdata
);
    ggv_pkg::ggv_cfg_t    cfg_reg;
    ggv_pkg::ggv_iter_t   stg [ggv_pkg::ITER_STAGES+1];
    logic                 en;
    logic signed [15:0]   linear_cmd, angular_cmd;
    ggv_pkg::ggv_status_t status;

    // Whole pipeline advances together whenever the output slot frees up.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_tolerance  <= 15'd410;
            cfg_reg.linear_gain     <= 15'd2048;
            cfg_reg.linear_max      <= 15'd2458;
            cfg_reg.steer_gain      <= 15'd4915;
            cfg_reg.angle_tolerance <= 15'd82;
            cfg_reg.turn_gain       <= 15'd4096;
            cfg_reg.angular_max     <= 15'd3277;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ggv_pkg::REG_DIST_TOL:  cfg_reg.dist_tolerance  <= cfg_wdata;
                ggv_pkg::REG_LIN_GAIN:  cfg_reg.linear_gain     <= cfg_wdata;
                ggv_pkg::REG_LIN_MAX:   cfg_reg.linear_max      <= cfg_wdata;
                ggv_pkg::REG_STEER_GN:  cfg_reg.steer_gain      <= cfg_wdata;
                ggv_pkg::REG_ANGLE_TOL: cfg_reg.angle_tolerance <= cfg_wdata;
                ggv_pkg::REG_TURN_GAIN: cfg_reg.turn_gain       <= cfg_wdata;
                ggv_pkg::REG_ANG_MAX:   cfg_reg.angular_max     <= cfg_wdata;
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // Squares, quadrant fold, heading wrap/round, distance test.
    ggv_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_vld        (s_tvalid),
        .offset_x      (s_tdata[15:0]),
        .offset_y      (s_tdata[31:16]),
        .heading_error (s_tdata[47:32]),
        .cancel        (s_tuser),
        .cfg           (cfg_reg),
        .stg_o         (stg[0])
    );

    // Bearing CORDIC and distance square root run side by side, one step per stage.
    for (genvar k = 0; k < ggv_pkg::ITER_STAGES; k++) begin : g_iter
        ggv_iter u_iter (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .step_idx (5'(k)),
            .stg_i    (stg[k]),
            .stg_o    (stg[k+1])
        );
    end

    // Gains, limits, mode select, output register.
    ggv_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .stg_i       (stg[ggv_pkg::ITER_STAGES]),
        .cfg         (cfg_reg),
        .out_vld     (m_tvalid),
        .linear_cmd  (linear_cmd),
        .angular_cmd (angular_cmd),
        .status      (status)
    );

    assign m_tdata = {6'b0, status, angular_cmd, linear_cmd};

    // A canceled tick never commands motion.
    `GGV_ASSERT_NOW(a_cancel_stops, m_tvalid && status == ggv_pkg::ST_CANCEL, linear_cmd == 16'sd0 && angular_cmd == 16'sd0, "canceled tick with nonzero command")
    // Reached goal holds still.
    `GGV_ASSERT_NOW(a_reached_still, m_tvalid && status == ggv_pkg::ST_REACHED, linear_cmd == 16'sd0 && angular_cmd == 16'sd0, "reached tick with nonzero command")
    // Turning in place stays within the angular clamp.
    `GGV_ASSERT_NOW(a_align_clamp, m_tvalid && status == ggv_pkg::ST_ALIGN, linear_cmd == 16'sd0 && angular_cmd <= $signed({1'b0, cfg_reg.angular_max}) && angular_cmd >= -$signed({1'b0, cfg_reg.angular_max}), "align command outside clamp")
    // Driving speed never passes the limit and never goes backward.
    `GGV_ASSERT_NOW(a_drive_limit, m_tvalid && status == ggv_pkg::ST_DRIVE, linear_cmd >= 16'sd0 && linear_cmd <= $signed({1'b0, cfg_reg.linear_max}), "linear command beyond limit")
    // A held result freezes the pipeline for the next cycle.
    `GGV_ASSERT_NEXT(a_hold_output, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(stg[0]), "pipeline moved while output stalled")

endmodule

@@ hdl/ggv_front.sv @@
`timescale 1ns / 1ps
// Two stages: squares, quadrant fold, heading wrap; then sum, range test, heading round.
module ggv_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic signed [15:0]    offset_x,
    input  logic signed [15:0]    offset_y,
    input  logic signed [15:0]    heading_error,
    input  logic                  cancel,
    input  ggv_pkg::ggv_cfg_t     cfg,
    output ggv_pkg::ggv_iter_t    stg_o
);
    logic                          vld1_reg, vld2_reg;
    logic                          cancel1_reg;
    logic [30:0]                   sqx_reg, sqy_reg;
    logic signed [ggv_pkg::XW-1:0] x1_reg, y1_reg;
    logic signed [ggv_pkg::ZW-1:0] z1_reg;
    logic signed [ggv_pkg::EW-1:0] e1_reg;
    ggv_pkg::ggv_iter_t            s2_reg;

    logic signed [ggv_pkg::XW-1:0] xp, yp, x1_next, y1_next;
    logic signed [ggv_pkg::ZW-1:0] z1_next;
    logic signed [ggv_pkg::EW-1:0] e_raw, e1_next, e_rnd;
    logic signed [31:0]            sqx_s, sqy_s;
    logic [31:0]                   d2;

    always_comb begin
        xp = ggv_pkg::XW'(offset_x) <<< 14;
        yp = ggv_pkg::XW'(offset_y) <<< 14;
        x1_next = xp;
        y1_next = yp;
        z1_next = '0;
        if (xp < 0) begin
            if (yp >= 0) begin
                x1_next = yp;
                y1_next = -xp;
                z1_next = ggv_pkg::HALF_PI_U30;
            end else begin
                x1_next = -yp;
                y1_next = xp;
                z1_next = -ggv_pkg::HALF_PI_U30;
            end
        end
        e_raw = ggv_pkg::EW'(heading_error) <<< ggv_pkg::RND_SHIFT;
        if (e_raw > ggv_pkg::PI_U30)
            e1_next = e_raw - ggv_pkg::TWO_PI_U30;
        else if (e_raw <= -ggv_pkg::PI_U30)
            e1_next = e_raw + ggv_pkg::TWO_PI_U30;
        else
            e1_next = e_raw;
        sqx_s = offset_x * offset_x;
        sqy_s = offset_y * offset_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cancel1_reg <= cancel;
            sqx_reg     <= sqx_s[30:0];
            sqy_reg     <= sqy_s[30:0];
            x1_reg      <= x1_next;
            y1_reg      <= y1_next;
            z1_reg      <= z1_next;
            e1_reg      <= e1_next;
        end
    end

    always_comb begin
        d2    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        e_rnd = (e1_reg + (ggv_pkg::EW'(1) <<< (ggv_pkg::RND_SHIFT - 1))) >>> ggv_pkg::RND_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg.vld    <= vld1_reg;
            s2_reg.cancel <= cancel1_reg;
            s2_reg.drive  <= d2 > (32'(cfg.dist_tolerance) * 32'(cfg.dist_tolerance));
            s2_reg.err_q  <= e_rnd[15:0];
            s2_reg.x      <= x1_reg;
            s2_reg.y      <= y1_reg;
            s2_reg.z      <= z1_reg;
            s2_reg.rem    <= d2;
            s2_reg.root   <= '0;
        end
    end

    always_comb begin
        stg_o     = s2_reg;
        stg_o.vld = vld2_reg;
    end

endmodule

@@ hdl/ggv_iter.sv @@
`timescale 1ns / 1ps
// One CORDIC vectoring step and one square-root digit per stage.
module ggv_iter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [4:0]            step_idx,
    input  ggv_pkg::ggv_iter_t    stg_i,
    output ggv_pkg::ggv_iter_t    stg_o
);
    ggv_pkg::ggv_iter_t            s_reg, s_next;
    logic                          vld_reg;
    logic signed [ggv_pkg::XW-1:0] xs, ys;
    logic [31:0]                   sbit, trial;
    logic [5:0]                    sh;

    always_comb begin
        s_next = stg_i;
        xs     = stg_i.x >>> step_idx;
        ys     = stg_i.y >>> step_idx;
        sh     = 6'd30 - {step_idx, 1'b0};
        sbit   = 32'd1 << sh;
        trial  = stg_i.root + sbit;
        if (32'(step_idx) < 32'(ggv_pkg::CORDIC_STEPS)) begin
            if (stg_i.y > 0) begin
                s_next.x = stg_i.x + ys;
                s_next.y = stg_i.y - xs;
                s_next.z = stg_i.z + ggv_pkg::atan_u30(step_idx);
            end else begin
                s_next.x = stg_i.x - ys;
                s_next.y = stg_i.y + xs;
                s_next.z = stg_i.z - ggv_pkg::atan_u30(step_idx);
            end
        end
        if (32'(step_idx) < 32'(ggv_pkg::SQRT_STEPS)) begin
            if (stg_i.rem >= trial) begin
                s_next.rem  = stg_i.rem - trial;
                s_next.root = (stg_i.root >> 1) + sbit;
            end else begin
                s_next.root = stg_i.root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= stg_i.vld;
    end

    always_ff @(posedge aclk) begin
        if (en)
            s_reg <= s_next;
    end

    always_comb begin
        stg_o     = s_reg;
        stg_o.vld = vld_reg;
    end

endmodule

@@ hdl/ggv_out.sv @@
`timescale 1ns / 1ps
// Gain multiplies, then clamp/saturate and mode select into the output register.
module ggv_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  ggv_pkg::ggv_iter_t    stg_i,
    input  ggv_pkg::ggv_cfg_t     cfg,
    output logic                  out_vld,
    output logic signed [15:0]    linear_cmd,
    output logic signed [15:0]    angular_cmd,
    output ggv_pkg::ggv_status_t  status
);
    logic                 vld1_reg, vld2_reg;
    logic                 cancel_reg, drive_reg, align_reg;
    logic [30:0]          lin_prod_reg;
    logic signed [31:0]   steer_prod_reg, turn_prod_reg;
    logic signed [15:0]   lin_reg, ang_reg;
    ggv_pkg::ggv_status_t st_reg;

    logic signed [ggv_pkg::ZW-1:0] z_rnd;
    logic signed [15:0]   brg, emag;
    logic [18:0]          lin_sh;
    logic signed [19:0]   steer_sh, turn_sh;
    logic signed [19:0]   amax;
    logic signed [15:0]   lin_next, ang_next, steer_sat, turn_clamp;
    ggv_pkg::ggv_status_t st_next;

    always_comb begin
        z_rnd = (stg_i.z + (ggv_pkg::ZW'(1) <<< (ggv_pkg::RND_SHIFT - 1))) >>> ggv_pkg::RND_SHIFT;
        brg   = z_rnd[15:0];
        emag  = (stg_i.err_q < 0) ? -stg_i.err_q : stg_i.err_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= stg_i.vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cancel_reg     <= stg_i.cancel;
            drive_reg      <= stg_i.drive;
            align_reg      <= $unsigned(emag) > 16'(cfg.angle_tolerance);
            lin_prod_reg   <= 31'(cfg.linear_gain) * stg_i.root[15:0];
            steer_prod_reg <= $signed({1'b0, cfg.steer_gain}) * brg;
            turn_prod_reg  <= $signed({1'b0, cfg.turn_gain}) * stg_i.err_q;
        end
    end

    always_comb begin
        lin_sh   = lin_prod_reg[30:ggv_pkg::FRAC_BITS];
        steer_sh = steer_prod_reg[31:ggv_pkg::FRAC_BITS];
        turn_sh  = turn_prod_reg[31:ggv_pkg::FRAC_BITS];
        amax     = 20'(cfg.angular_max);
        if (steer_sh > 20'sd32767)
            steer_sat = 16'sh7FFF;
        else if (steer_sh < -20'sd32768)
            steer_sat = -16'sh8000;
        else
            steer_sat = steer_sh[15:0];
        if (turn_sh > amax)
            turn_clamp = amax[15:0];
        else if (turn_sh < -amax)
            turn_clamp = -amax[15:0];
        else
            turn_clamp = turn_sh[15:0];
        lin_next = '0;
        ang_next = '0;
        if (cancel_reg) begin
            st_next = ggv_pkg::ST_CANCEL;
        end else if (drive_reg) begin
            st_next  = ggv_pkg::ST_DRIVE;
            lin_next = (lin_sh > 19'(cfg.linear_max)) ? 16'(cfg.linear_max) : lin_sh[15:0];
            ang_next = steer_sat;
        end else if (align_reg) begin
            st_next  = ggv_pkg::ST_ALIGN;
            ang_next = turn_clamp;
        end else begin
            st_next = ggv_pkg::ST_REACHED;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
            st_reg  <= st_next;
        end
    end

    assign out_vld     = vld2_reg;
    assign linear_cmd  = lin_reg;
    assign angular_cmd = ang_reg;
    assign status      = st_reg;

endmodule
